// File: rtl/udsdid_pkg.sv
// Package: request and response item types, sequencer control store and slot table.
package udsdid_pkg;

    typedef struct packed {
        logic [7:0] service_id;
        logic [7:0] req_byte1;
        logic [7:0] req_byte2;
        logic [7:0] req_byte3;
        logic [7:0] req_byte4;
    } t_req;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_last;
        logic [2:0] action;
        logic       no_frame;
    } t_rsp;

    localparam int unsigned TABLE_MAX = 16;
    localparam int unsigned UPC_W     = 5;
    localparam int unsigned POS_W     = 4;

    localparam logic [7:0] SID_ECU_RESET  = 8'h11;
    localparam logic [7:0] SID_CLEAR_DIAG = 8'h14;
    localparam logic [7:0] SID_READ_DTC   = 8'h19;
    localparam logic [7:0] SID_READ_DID   = 8'h22;
    localparam logic [7:0] SID_WRITE_DID  = 8'h2E;

    localparam logic [7:0] NRC_SERVICE = 8'h11;
    localparam logic [7:0] NRC_SUBFUNC = 8'h12;
    localparam logic [7:0] NRC_RANGE   = 8'h31;

    localparam logic [7:0] SUBF_SOFT      = 8'h02;
    localparam logic [7:0] SUBF_DTC_MASK  = 8'h02;
    localparam logic [7:0] POS_OFFSET     = 8'h40;
    localparam logic [7:0] NEG_HEADER     = 8'h7F;
    localparam logic [7:0] TERMINATOR     = 8'h0D;
    localparam logic [POS_W-1:0] PAD_END_POS = 4'd9;

    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_DUTY    = 3'd1;
    localparam logic [2:0] ACT_FREQ    = 3'd2;
    localparam logic [2:0] ACT_RLY_IN  = 3'd3;
    localparam logic [2:0] ACT_RLY_OUT = 3'd4;
    localparam logic [2:0] ACT_CLEAR   = 3'd5;
    localparam logic [2:0] ACT_DTC     = 3'd6;
    localparam logic [2:0] ACT_RESET   = 3'd7;

    typedef enum logic [3:0] {
        SEL_ZERO = 4'd0,
        SEL_HDR  = 4'd1,
        SEL_NEG  = 4'd2,
        SEL_SID  = 4'd3,
        SEL_B1   = 4'd4,
        SEL_B2   = 4'd5,
        SEL_NRC  = 4'd6,
        SEL_LO   = 4'd7,
        SEL_HI   = 4'd8,
        SEL_SUM  = 4'd9,
        SEL_CR   = 4'd10
    } t_sel;

    typedef enum logic [1:0] {
        JMP_SEQ  = 2'd0,
        JMP_GOTO = 2'd1,
        JMP_PAD  = 2'd2
    } t_jmp;

    typedef struct packed {
        t_sel             sel;
        logic             last;
        logic             no_frame;
        logic             done;
        t_jmp             jmp;
        logic [UPC_W-1:0] target;
    } t_uop;

    localparam logic [UPC_W-1:0] UA_ECU   = 5'd0;
    localparam logic [UPC_W-1:0] UA_PAD   = 5'd2;
    localparam logic [UPC_W-1:0] UA_CLEAR = 5'd5;
    localparam logic [UPC_W-1:0] UA_READ  = 5'd6;
    localparam logic [UPC_W-1:0] UA_WRITE = 5'd11;
    localparam logic [UPC_W-1:0] UA_NEG   = 5'd14;
    localparam logic [UPC_W-1:0] UA_DTC   = 5'd17;
    localparam logic [UPC_W-1:0] UA_LAST  = 5'd17;

    function automatic t_uop mk(t_sel s, logic l, logic nf, logic d, t_jmp j,
                                logic [UPC_W-1:0] t);
        t_uop u;
        u.sel = s; u.last = l; u.no_frame = nf; u.done = d; u.jmp = j; u.target = t;
        return u;
    endfunction

    function automatic t_uop uop_rom(logic [UPC_W-1:0] a);
        t_uop u;
        case (a)
            5'd0:    u = mk(SEL_HDR,  1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd1:    u = mk(SEL_B1,   1'b0, 1'b0, 1'b0, JMP_GOTO, UA_PAD);
            5'd2:    u = mk(SEL_ZERO, 1'b0, 1'b0, 1'b0, JMP_PAD,  '0);
            5'd3:    u = mk(SEL_SUM,  1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd4:    u = mk(SEL_CR,   1'b1, 1'b0, 1'b1, JMP_SEQ,  '0);
            5'd5:    u = mk(SEL_HDR,  1'b0, 1'b0, 1'b0, JMP_GOTO, UA_PAD);
            5'd6:    u = mk(SEL_HDR,  1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd7:    u = mk(SEL_B1,   1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd8:    u = mk(SEL_B2,   1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd9:    u = mk(SEL_LO,   1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd10:   u = mk(SEL_HI,   1'b0, 1'b0, 1'b0, JMP_GOTO, UA_PAD);
            5'd11:   u = mk(SEL_HDR,  1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd12:   u = mk(SEL_B1,   1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd13:   u = mk(SEL_B2,   1'b0, 1'b0, 1'b0, JMP_GOTO, UA_PAD);
            5'd14:   u = mk(SEL_NEG,  1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd15:   u = mk(SEL_SID,  1'b0, 1'b0, 1'b0, JMP_SEQ,  '0);
            5'd16:   u = mk(SEL_NRC,  1'b0, 1'b0, 1'b0, JMP_GOTO, UA_PAD);
            5'd17:   u = mk(SEL_ZERO, 1'b1, 1'b1, 1'b1, JMP_SEQ,  '0);
            default: u = mk(SEL_ZERO, 1'b1, 1'b0, 1'b1, JMP_SEQ,  '0);
        endcase
        return u;
    endfunction

    function automatic logic [15:0] slot_ident(logic [3:0] i);
        logic [15:0] r;
        if (i < 4'd10) begin
            r = 16'h0100 + {12'd0, i};
        end else begin
            r = 16'h0110 + {12'd0, i - 4'd10};
        end
        return r;
    endfunction

    function automatic logic slot_wide(logic [3:0] i);
        return (i == 4'd0) || (i == 4'd1);
    endfunction

    function automatic logic [2:0] slot_action(logic [3:0] i);
        logic [2:0] r;
        case (i)
            4'd0:    r = ACT_DUTY;
            4'd1:    r = ACT_FREQ;
            4'd4:    r = ACT_RLY_IN;
            4'd5:    r = ACT_RLY_OUT;
            default: r = ACT_NONE;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/uds_did_request_handler.sv
// Diagnostic read/write-by-identifier server: decoder, slot store and microcoded frame emitter.
// Usage:
//   Request channel: i_req_valid / o_req_ready carry one item (service id and four bytes).
//   Response channel: o_rsp_valid / i_rsp_ready carry frame bytes, one item per byte.
//   Each request yields a twelve-byte frame (header, data, zero padding, modulo-256
//   checksum, 0x0D terminator) or, for a DTC report, a single no_frame item.
//   The request is decoded and any slot write is done in the accept cycle; the
//   first byte is registered into the output register at the sequencer's first
//   step, then one byte per cycle while the receiver takes them. A new request
//   is taken the cycle after the last step of a frame (or DTC report) issues.
//   The byte rate is set by the single byte-wide output register fed by the
//   microcode step counter: one control word, one byte.
//   When the receiver stalls, the sequencer holds its step and the output byte.
//   Reset clears all identifier slots to zero and empties the sequencer and
//   output register.
//   NUM_IDS (1..16) sets how many identifier slots exist.
module uds_did_request_handler #(
    parameter int unsigned NUM_IDS = 11
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  udsdid_pkg::t_req   i_req,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    output udsdid_pkg::t_rsp   o_rsp
);

    localparam int unsigned SLOT_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

    logic [15:0]                   r_store [NUM_IDS];
    logic                          r_busy;
    logic [udsdid_pkg::UPC_W-1:0]  r_pc;
    logic [udsdid_pkg::POS_W-1:0]  r_pos;
    logic [7:0]                    r_sum;
    logic [7:0]                    r_sid;
    logic [7:0]                    r_b1;
    logic [7:0]                    r_b2;
    logic [7:0]                    r_nrc;
    logic [2:0]                    r_act;
    logic [SLOT_W-1:0]             r_slot;
    logic                          r_wide;
    logic                          r_out_valid;
    udsdid_pkg::t_rsp              r_out;

    logic                          req_acc;
    logic                          step;
    logic                          found;
    logic [SLOT_W-1:0]             hit_idx;
    logic                          hit_wide;
    logic [2:0]                    hit_act;
    logic [udsdid_pkg::UPC_W-1:0]  n_pc;
    logic [7:0]                    n_nrc;
    logic [2:0]                    n_act;
    logic                          do_write;
    logic [15:0]                   wr_val;
    udsdid_pkg::t_uop              uop;
    logic [7:0]                    cur_byte;
    logic [15:0]                   cur_val;
    logic [udsdid_pkg::UPC_W-1:0]  n_step_pc;

    function automatic logic slot_hit(int i, logic [15:0] ident);
        return udsdid_pkg::slot_ident(4'(i)) == ident;
    endfunction

    assign o_req_ready = !r_busy;
    assign req_acc     = i_req_valid && o_req_ready;
    assign step        = r_busy && (!r_out_valid || i_rsp_ready);
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // identifier lookup
    always_comb begin
        found    = 1'b0;
        hit_idx  = '0;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (slot_hit(i, {i_req.req_byte1, i_req.req_byte2})) begin
                found   = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
        hit_wide = udsdid_pkg::slot_wide(4'(hit_idx));
        hit_act  = udsdid_pkg::slot_action(4'(hit_idx));
    end

    // request decode: entry point, NRC, action
    always_comb begin
        n_pc     = udsdid_pkg::UA_NEG;
        n_nrc    = udsdid_pkg::NRC_SERVICE;
        n_act    = udsdid_pkg::ACT_NONE;
        do_write = 1'b0;
        case (i_req.service_id)
            udsdid_pkg::SID_ECU_RESET: begin
                if (i_req.req_byte1 == udsdid_pkg::SUBF_SOFT) begin
                    n_pc  = udsdid_pkg::UA_ECU;
                    n_act = udsdid_pkg::ACT_RESET;
                end else begin
                    n_nrc = udsdid_pkg::NRC_SUBFUNC;
                end
            end
            udsdid_pkg::SID_CLEAR_DIAG: begin
                n_pc  = udsdid_pkg::UA_CLEAR;
                n_act = udsdid_pkg::ACT_CLEAR;
            end
            udsdid_pkg::SID_READ_DTC: begin
                if (i_req.req_byte1 == udsdid_pkg::SUBF_DTC_MASK) begin
                    n_pc  = udsdid_pkg::UA_DTC;
                    n_act = udsdid_pkg::ACT_DTC;
                end else begin
                    n_nrc = udsdid_pkg::NRC_SUBFUNC;
                end
            end
            udsdid_pkg::SID_READ_DID: begin
                if (found) begin
                    n_pc = udsdid_pkg::UA_READ;
                end else begin
                    n_nrc = udsdid_pkg::NRC_RANGE;
                end
            end
            udsdid_pkg::SID_WRITE_DID: begin
                if (found) begin
                    n_pc     = udsdid_pkg::UA_WRITE;
                    n_act    = hit_act;
                    do_write = 1'b1;
                end else begin
                    n_nrc = udsdid_pkg::NRC_RANGE;
                end
            end
            default: begin
                n_nrc = udsdid_pkg::NRC_SERVICE;
            end
        endcase
        wr_val = hit_wide ? {i_req.req_byte4, i_req.req_byte3} : {8'd0, i_req.req_byte3};
    end

    // datapath byte select and next step
    always_comb begin
        uop     = udsdid_pkg::uop_rom(r_pc);
        cur_val = r_store[r_slot];
        case (uop.sel)
            udsdid_pkg::SEL_ZERO: cur_byte = 8'd0;
            udsdid_pkg::SEL_HDR:  cur_byte = 8'(r_sid + udsdid_pkg::POS_OFFSET);
            udsdid_pkg::SEL_NEG:  cur_byte = udsdid_pkg::NEG_HEADER;
            udsdid_pkg::SEL_SID:  cur_byte = r_sid;
            udsdid_pkg::SEL_B1:   cur_byte = r_b1;
            udsdid_pkg::SEL_B2:   cur_byte = r_b2;
            udsdid_pkg::SEL_NRC:  cur_byte = r_nrc;
            udsdid_pkg::SEL_LO:   cur_byte = cur_val[7:0];
            udsdid_pkg::SEL_HI:   cur_byte = r_wide ? cur_val[15:8] : 8'd0;
            udsdid_pkg::SEL_SUM:  cur_byte = r_sum;
            udsdid_pkg::SEL_CR:   cur_byte = udsdid_pkg::TERMINATOR;
            default:              cur_byte = 8'd0;
        endcase
        case (uop.jmp)
            udsdid_pkg::JMP_SEQ:  n_step_pc = r_pc + 1'b1;
            udsdid_pkg::JMP_GOTO: n_step_pc = uop.target;
            udsdid_pkg::JMP_PAD:  n_step_pc = (r_pos == udsdid_pkg::PAD_END_POS) ?
                                              r_pc + 1'b1 : r_pc;
            default:              n_step_pc = r_pc + 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_IDS; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (req_acc) begin
                r_busy <= 1'b1;
                r_pc   <= n_pc;
                r_pos  <= '0;
                if (do_write) begin
                    r_store[hit_idx] <= wr_val;
                end
            end else if (step) begin
                r_pc  <= n_step_pc;
                r_pos <= r_pos + 1'b1;
                if (uop.done) begin
                    r_busy <= 1'b0;
                end
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_sid  <= i_req.service_id;
            r_b1   <= i_req.req_byte1;
            r_b2   <= i_req.req_byte2;
            r_nrc  <= n_nrc;
            r_act  <= n_act;
            r_slot <= hit_idx;
            r_wide <= hit_wide;
            r_sum  <= '0;
        end else if (step) begin
            r_sum <= r_sum + cur_byte;
        end
        if (step) begin
            r_out.tx_byte    <= cur_byte;
            r_out.frame_last <= uop.last;
            r_out.action     <= r_act;
            r_out.no_frame   <= uop.no_frame;
        end
    end

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= udsdid_pkg::UA_LAST))
        else $error("sequencer step out of control store");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < 4'd12))
        else $error("frame longer than twelve bytes");

    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_busy)
        else $error("accepted item not in progress");

    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.frame_last && !o_rsp.no_frame) |->
            (o_rsp.tx_byte == udsdid_pkg::TERMINATOR))
        else $error("frame end without terminator");

    a_noframe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.no_frame) |-> o_rsp.frame_last)
        else $error("no_frame item not marked last");

endmodule
